### rtl/base64_urlsafe_encoder_unit_defines.svh
// assertion macros for the url-safe base64 encoder
`ifndef BASE64_URLSAFE_ENCODER_UNIT_DEFINES_SVH
`define BASE64_URLSAFE_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while rst_n is low
`define B64U_ASSERT_NOW(label, cond, prop, text) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(text);

// next-cycle implication, sampled on clk, quiet while rst_n is low
`define B64U_ASSERT_NEXT(label, cond, prop, text) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(text);

`endif

### rtl/b64u_pkg.sv
// shared types, constants and the character lookup of the base64url encoder
package b64u_pkg;

    localparam int CODE_W      = 7;
    localparam int GROUP_CHARS = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] PAD_CODE = 7'd64;

    typedef logic [CODE_W-1:0] code_t;

    // one three-byte group, already split into sextet codes
    typedef struct packed {
        code_t [GROUP_CHARS-1:0] codes;
        logic                    fin;
    } group_t;

    // queue status reported by the queue and checked by the top-level assertions
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // sextet code to ascii, code 64 gives the '=' pad
    function automatic logic [7:0] sextet_char(input code_t code);
        logic [7:0] c8;
        logic [7:0] ch;
        c8 = {1'b0, code};
        if (c8 < 8'd26)
        begin
            ch = c8 + 8'd65;
        end
        else if (c8 < 8'd52)
        begin
            ch = c8 + 8'd71;
        end
        else if (c8 < 8'd62)
        begin
            ch = c8 - 8'd4;
        end
        else if (c8 == 8'd62)
        begin
            ch = 8'h2D;
        end
        else if (c8 == 8'd63)
        begin
            ch = 8'h5F;
        end
        else
        begin
            ch = 8'h3D;
        end
        return ch;
    endfunction

endpackage

### rtl/b64u_channels.sv
// handshake channels for message bytes and encoded characters
interface b64u_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface b64u_enc_if;
    logic       valid;
    logic       ready;
    logic [7:0] enc_char;
    logic       group_last;
    logic       message_last;

    modport source (output valid, output enc_char, output group_last,
                    output message_last, input ready);
    modport sink   (input valid, input enc_char, input group_last,
                    input message_last, output ready);
endinterface

### rtl/b64u_front.sv
// front end: gathers bytes into groups and splits them into sextet codes
module b64u_front (
    input  logic              clk,
    input  logic              rst_n,
    b64u_msg_if.sink          msg,
    output logic              push_valid,
    input  logic              push_ready,
    output b64u_pkg::group_t  push_group
);
    import b64u_pkg::*;

    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic [15:0] pend_reg;
    logic [15:0] pend_next;
    logic        accept;
    logic        closes;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;

    assign msg.ready  = push_ready;
    assign accept     = msg.valid && push_ready;
    assign closes     = (cnt_reg == 2'd2) || msg.is_final;
    assign push_valid = msg.valid && closes;

    // group bytes, missing ones read as zero
    always_comb
    begin
        b0 = (cnt_reg == 2'd0) ? msg.data_byte : pend_reg[15:8];
        case (cnt_reg)
            2'd0:    b1 = 8'h00;
            2'd1:    b1 = msg.data_byte;
            default: b1 = pend_reg[7:0];
        endcase
        b2 = (cnt_reg == 2'd2) ? msg.data_byte : 8'h00;
    end

    always_comb
    begin
        push_group.codes[0] = {1'b0, b0[7:2]};
        push_group.codes[1] = {1'b0, b0[1:0], b1[7:4]};
        push_group.codes[2] = (cnt_reg == 2'd0) ? PAD_CODE : {1'b0, b1[3:0], b2[7:6]};
        push_group.codes[3] = (cnt_reg != 2'd2) ? PAD_CODE : {1'b0, b2[5:0]};
        push_group.fin      = msg.is_final;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        if (accept)
        begin
            if (closes)
            begin
                cnt_next = 2'd0;
            end
            else
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    pend_next = {msg.data_byte, 8'h00};
                end
                else
                begin
                    pend_next = {pend_reg[15:8], msg.data_byte};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            pend_reg <= 16'h0000;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

endmodule

### rtl/b64u_queue.sv
// short group queue between front end and character back end
module b64u_queue #(
    parameter int DEPTH = b64u_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  b64u_pkg::group_t     push_group,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output b64u_pkg::group_t     pop_group,
    output b64u_pkg::q_status_t  status
);
    import b64u_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    group_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full      = (count_reg == CNT_W'(DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign push_ready       = !status.full;
    assign pop_valid        = status.not_empty;
    assign pop_group        = mem[rd_ptr_reg];
    assign do_push          = push_valid && push_ready;
    assign do_pop           = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_group;
        end
    end

endmodule

### rtl/b64u_back.sv
// back end: emits the four characters of each group, one per cycle while enc is ready
module b64u_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  b64u_pkg::group_t  pop_group,
    output logic              busy,
    b64u_enc_if.source        enc
);
    import b64u_pkg::*;

    group_t     grp_reg;
    group_t     grp_next;
    logic       grp_valid_reg;
    logic       grp_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] char_reg;
    logic [7:0] char_next;
    logic       glast_reg;
    logic       glast_next;
    logic       mlast_reg;
    logic       mlast_next;
    logic       advance;
    logic       last_char;
    logic       do_pop;

    assign advance   = grp_valid_reg && (!out_valid_reg || enc.ready);
    assign last_char = (idx_reg == 2'd3);
    assign pop_ready = !grp_valid_reg || (advance && last_char);
    assign do_pop    = pop_valid && pop_ready;
    assign busy      = grp_valid_reg;

    assign enc.valid        = out_valid_reg;
    assign enc.enc_char     = char_reg;
    assign enc.group_last   = glast_reg;
    assign enc.message_last = mlast_reg;

    always_comb
    begin
        grp_next       = grp_reg;
        grp_valid_next = grp_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        glast_next     = glast_reg;
        mlast_next     = mlast_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            char_next      = sextet_char(grp_reg.codes[idx_reg]);
            glast_next     = last_char;
            mlast_next     = last_char && grp_reg.fin;
            idx_next       = idx_reg + 2'd1;
            if (last_char)
            begin
                grp_valid_next = 1'b0;
            end
        end
        else if (enc.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (do_pop)
        begin
            grp_next       = pop_group;
            grp_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grp_valid_reg <= grp_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        char_reg  <= char_next;
        glast_reg <= glast_next;
        mlast_reg <= mlast_next;
    end

endmodule

### rtl/base64_urlsafe_encoder_unit.sv
// url-safe base64 encoder with '=' padding, one message byte in, one character out
//
// Bytes arrive on msg, one per request, with is_final on the last byte of a
// message. Every group of three bytes, and a shorter group closed by the final
// byte, leaves as four characters from A-Z a-z 0-9 - _ on enc, with '=' in
// place of missing sextets; group_last marks the fourth character and
// message_last the fourth character of the closing group. A byte is taken in
// the cycle it is offered while the group queue has room, so bytes may follow
// back to back; the character side gives one character per cycle while enc
// is ready, so sustained throughput is three bytes per four characters, set
// by the single character register of the back end. A group's first character
// passes the queue, then the group and character registers of the back end.
// The front end and back end are parted by a queue of QUEUE_DEPTH groups so a
// stall on enc does not reach msg until the queue is full.
`include "base64_urlsafe_encoder_unit_defines.svh"

module base64_urlsafe_encoder_unit #(
    parameter int QUEUE_DEPTH = b64u_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    b64u_msg_if.sink     msg,
    b64u_enc_if.source   enc
);
    import b64u_pkg::*;

    // front end to queue
    logic       push_valid;
    logic       push_ready;
    group_t     push_group;

    // queue to back end
    logic       pop_valid;
    logic       pop_ready;
    group_t     pop_group;
    q_status_t  q_status;
    logic       back_busy;

    // byte gathering and sextet split
    b64u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group)
    );

    // decoupling queue of whole groups
    b64u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_group  (pop_group),
        .status     (q_status)
    );

    // character serialiser with output register
    b64u_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_group (pop_group),
        .busy      (back_busy),
        .enc       (enc)
    );

    // a full queue must hold off new bytes
    `B64U_ASSERT_NOW(a_full_blocks_input, q_status.full, !msg.ready, "byte taken with queue full")

    // message end only ever lands on the fourth character of a group
    `B64U_ASSERT_NOW(a_mlast_on_glast, enc.valid && enc.message_last, enc.group_last,
        "message_last without group_last")

    // an idle back end picks up a waiting group at once
    `B64U_ASSERT_NEXT(a_back_picks_up, q_status.not_empty && !back_busy, back_busy,
        "waiting group not picked up")

endmodule
